// ===== sv/fpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared types and constants for the frustum projection matrix pipeline.
// ----------------------------------------------------------------------------
package fpm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_LANES = 6;
    localparam int QUO_BITS  = 31;
    // Stage 0 prepares operands, stage 1 checks overflow, then one stage per
    // quotient bit.
    localparam int NUM_STAGES = QUO_BITS + 2;

    localparam int LANE_XS  = 0;
    localparam int LANE_YS  = 1;
    localparam int LANE_XO  = 2;
    localparam int LANE_YO  = 3;
    localparam int LANE_DS  = 4;
    localparam int LANE_DOF = 5;

    typedef logic signed [31:0] fix_t;

    typedef struct packed {
        logic [63:0]         rem;
        logic [32:0]         den;
        logic [QUO_BITS-1:0] quo;
        logic                neg;
        logic                sat;
    } lane_t;

    typedef struct packed {
        fix_t x_scale;
        fix_t y_scale;
        fix_t x_offset;
        fix_t y_offset;
        fix_t depth_scale;
        fix_t depth_offset;
        logic degenerate;
    } result_t;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        abs32 = v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [32:0] abs33(input logic [32:0] v);
        abs33 = v[32] ? (33'd0 - v) : v;
    endfunction

endpackage

// ===== sv/fpm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_if
// Valid/ready channels carrying a view volume word and a matrix word.
// ----------------------------------------------------------------------------
interface fpm_vol_if;
    logic                valid;
    logic                ready;
    fpm_pkg::fix_t       left_edge;
    fpm_pkg::fix_t       right_edge;
    fpm_pkg::fix_t       bottom_edge;
    fpm_pkg::fix_t       top_edge;
    fpm_pkg::fix_t       near_dist;
    fpm_pkg::fix_t       far_dist;

    modport source (output valid, left_edge, right_edge, bottom_edge, top_edge,
                    near_dist, far_dist, input ready);
    modport sink   (input valid, left_edge, right_edge, bottom_edge, top_edge,
                    near_dist, far_dist, output ready);
endinterface

interface fpm_mat_if;
    logic                valid;
    logic                ready;
    fpm_pkg::fix_t       x_scale;
    fpm_pkg::fix_t       y_scale;
    fpm_pkg::fix_t       x_offset;
    fpm_pkg::fix_t       y_offset;
    fpm_pkg::fix_t       depth_scale;
    fpm_pkg::fix_t       depth_offset;
    logic                degenerate;

    modport source (output valid, x_scale, y_scale, x_offset, y_offset,
                    depth_scale, depth_offset, degenerate, input ready);
    modport sink   (input valid, x_scale, y_scale, x_offset, y_offset,
                    depth_scale, depth_offset, degenerate, output ready);
endinterface

// ===== sv/frustum_projection_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_projection_matrix
// Perspective frustum matrix entries from a view volume, in Q16.16.
//
// One view volume word is accepted per clock while the second entry of the
// output buffer is empty; a full buffer stalls the whole pipeline. The
// differences, sums and the near*far product are formed in the accepting
// cycle, then come the overflow check, the six parallel restoring dividers
// producing one quotient bit each per stage, and the output register. The
// divider chain makes up most of the pipeline. A two-entry output buffer keeps
// the input ready while a finished word waits. Quotients truncate toward zero
// and saturate; zero width, height or depth sets degenerate and zeroes the
// affected entries.
// ----------------------------------------------------------------------------
module frustum_projection_matrix (
    input logic      clk,
    input logic      rst_n,
    fpm_vol_if.sink  vol,
    fpm_mat_if.source mat
);
    import fpm_pkg::*;

    lane_t   st_reg  [NUM_STAGES][NUM_LANES];
    logic    deg_reg [NUM_STAGES];
    logic    vld_reg [NUM_STAGES];
    lane_t   prep    [NUM_LANES];
    lane_t   ovf     [NUM_LANES];
    logic    prep_deg;
    result_t res_next;
    result_t out_reg;
    result_t skid_reg;
    logic    out_vld_reg;
    logic    skid_vld_reg;
    logic    adv;
    logic    push;

    logic [32:0] l33, r33, b33, t33, n33, f33;
    logic [32:0] w, h, d, sx, sy, sz;
    logic [31:0] n_mag, f_mag;
    logic [63:0] prod, near2;

    assign adv       = !skid_vld_reg;
    assign push      = adv && vld_reg[NUM_STAGES-1];
    assign vol.ready = adv;

    always_comb
    begin
        l33 = {vol.left_edge[31], vol.left_edge};
        r33 = {vol.right_edge[31], vol.right_edge};
        b33 = {vol.bottom_edge[31], vol.bottom_edge};
        t33 = {vol.top_edge[31], vol.top_edge};
        n33 = {vol.near_dist[31], vol.near_dist};
        f33 = {vol.far_dist[31], vol.far_dist};
        w  = r33 - l33;
        h  = t33 - b33;
        d  = f33 - n33;
        sx = l33 + r33;
        sy = b33 + t33;
        sz = f33 + n33;
        n_mag = abs32(vol.near_dist);
        f_mag = abs32(vol.far_dist);
        prod  = {32'd0, n_mag} * {32'd0, f_mag};
        near2 = {32'd0, n_mag} << (FRAC_BITS + 1);

        for (int i = 0; i < NUM_LANES; i++)
        begin
            prep[i] = '0;
        end
        prep[LANE_XS].rem  = near2;
        prep[LANE_XS].den  = abs33(w);
        prep[LANE_XS].neg  = n33[32] ^ w[32];
        prep[LANE_YS].rem  = near2;
        prep[LANE_YS].den  = abs33(h);
        prep[LANE_YS].neg  = n33[32] ^ h[32];
        prep[LANE_XO].rem  = {31'd0, abs33(sx)} << FRAC_BITS;
        prep[LANE_XO].den  = abs33(w);
        prep[LANE_XO].neg  = sx[32] ^ w[32];
        prep[LANE_YO].rem  = {31'd0, abs33(sy)} << FRAC_BITS;
        prep[LANE_YO].den  = abs33(h);
        prep[LANE_YO].neg  = sy[32] ^ h[32];
        prep[LANE_DS].rem  = {31'd0, abs33(sz)} << FRAC_BITS;
        prep[LANE_DS].den  = abs33(d);
        prep[LANE_DS].neg  = (!sz[32] && (sz != 33'd0)) ^ d[32];
        prep[LANE_DOF].rem = prod << 1;
        prep[LANE_DOF].den = abs33(d);
        prep[LANE_DOF].neg = ((prod != 64'd0) && !(n33[32] ^ f33[32])) ^ d[32];
        prep_deg = (w == 33'd0) || (h == 33'd0) || (d == 33'd0);
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            ovf[i]     = st_reg[0][i];
            ovf[i].quo = '0;
            ovf[i].sat = st_reg[0][i].rem >= {st_reg[0][i].den, 31'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= vol.valid;
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0]  <= prep;
            st_reg[1]  <= ovf;
            deg_reg[0] <= prep_deg;
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                deg_reg[k] <= deg_reg[k-1];
            end
        end
    end

    genvar gk, gi;
    generate
        for (gk = 2; gk < NUM_STAGES; gk++)
        begin : g_step
            for (gi = 0; gi < NUM_LANES; gi++)
            begin : g_lane
                localparam int BIT = NUM_STAGES - 1 - gk;
                logic [63:0] cand;
                lane_t       nxt;

                always_comb
                begin
                    cand = {31'd0, st_reg[gk-1][gi].den} << BIT;
                    nxt  = st_reg[gk-1][gi];
                    if (st_reg[gk-1][gi].rem >= cand)
                    begin
                        nxt.rem      = st_reg[gk-1][gi].rem - cand;
                        nxt.quo[BIT] = 1'b1;
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        st_reg[gk][gi] <= nxt;
                    end
                end
            end
        end
    endgenerate

    function automatic fix_t finish(input lane_t s);
        logic [31:0] q;
        q = {1'b0, s.quo};
        if (s.den == 33'd0)
            finish = '0;
        else if (s.sat)
            finish = s.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            finish = s.neg ? (32'd0 - q) : q;
    endfunction

    always_comb
    begin
        res_next.x_scale      = finish(st_reg[NUM_STAGES-1][LANE_XS]);
        res_next.y_scale      = finish(st_reg[NUM_STAGES-1][LANE_YS]);
        res_next.x_offset     = finish(st_reg[NUM_STAGES-1][LANE_XO]);
        res_next.y_offset     = finish(st_reg[NUM_STAGES-1][LANE_YO]);
        res_next.depth_scale  = finish(st_reg[NUM_STAGES-1][LANE_DS]);
        res_next.depth_offset = finish(st_reg[NUM_STAGES-1][LANE_DOF]);
        res_next.degenerate   = deg_reg[NUM_STAGES-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (mat.ready || !out_vld_reg)
        begin
            out_vld_reg  <= skid_vld_reg || push;
            skid_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mat.ready || !out_vld_reg)
        begin
            out_reg <= skid_vld_reg ? skid_reg : res_next;
        end
        else if (push)
        begin
            skid_reg <= res_next;
        end
    end

    assign mat.valid        = out_vld_reg;
    assign mat.x_scale      = out_reg.x_scale;
    assign mat.y_scale      = out_reg.y_scale;
    assign mat.x_offset     = out_reg.x_offset;
    assign mat.y_offset     = out_reg.y_offset;
    assign mat.depth_scale  = out_reg.depth_scale;
    assign mat.depth_offset = out_reg.depth_offset;
    assign mat.degenerate   = out_reg.degenerate;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("buffered word without a word on the output");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && mat.ready && skid_vld_reg) |=> (out_vld_reg && !skid_vld_reg))
        else $error("buffered word not moved to the output");

    a_pipe_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NUM_STAGES-1] && !skid_vld_reg) |=> out_vld_reg)
        else $error("word leaving the divider was lost");
`endif

endmodule
